// ----- sv/rrco_pkg.sv -----
// constants and register codes shared by the runup overload block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rrco_pkg;

    localparam int MAX_WAVES = 16384;

    // 1/log2(50) in q0.32
    localparam logic [31:0] RECIP_LOG2_50 = 32'd760998713;

    localparam int LOG_FRAC_BITS = 30;
    localparam int ISQ_STAGES    = 32;
    localparam int DIV_STAGES    = 16;
    localparam int DW            = 35;
    localparam int QUOT_STEPS    = 64;

    localparam logic [47:0] OUT_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] SAT64   = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [2:0] REG_WAVE_COUNT   = 3'd0;
    localparam logic [2:0] REG_CRIT_VEL     = 3'd1;
    localparam logic [2:0] REG_LOAD_FACTOR  = 3'd2;
    localparam logic [2:0] REG_STRENGTH     = 3'd3;
    localparam logic [2:0] REG_VEL_COEFF    = 3'd4;
    localparam logic [2:0] REG_GRAVITY      = 3'd5;

    localparam logic [14:0] RST_WAVE_COUNT  = 15'd10000;
    localparam logic [31:0] RST_CRIT_VEL    = 32'd432538;
    localparam logic [31:0] RST_LOAD_FACTOR = 32'd65536;
    localparam logic [31:0] RST_STRENGTH    = 32'd65536;
    localparam logic [31:0] RST_VEL_COEFF   = 32'd72090;
    localparam logic [31:0] RST_GRAVITY     = 32'd642908;

endpackage

`default_nettype wire

// ----- sv/rrco_log2.sv -----
// pipelined base-2 logarithm of a small integer, result in q.30
// uses rrco_pkg for the fraction length
`timescale 1ns / 1ps
`default_nettype none

module rrco_log2 #(
    parameter int XW = 15
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    input  wire logic [XW-1:0]                           x,
    output logic                                         out_valid,
    output logic [$clog2(XW)+rrco_pkg::LOG_FRAC_BITS-1:0] y
);

    localparam int EW = $clog2(XW);
    localparam int FB = rrco_pkg::LOG_FRAC_BITS;

    logic [EW-1:0]     e_reg     [0:FB];
    logic [FB:0]       m_reg     [0:FB];
    logic [FB-1:0]     frac_reg  [0:FB];
    logic              valid_reg [0:FB];

    logic [EW-1:0]     lead;
    logic [XW+FB:0]    shifted;

    // leading one position
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (x[i])
            begin
                lead = EW'(i);
            end
        end
        shifted = {{(FB+1){1'b0}}, x} << (FB - int'(lead));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg[0]    <= lead;
        m_reg[0]    <= shifted[FB:0];
        frac_reg[0] <= '0;
    end

    // one fraction bit per stage by mantissa squaring
    for (genvar s = 1; s <= FB; s++)
    begin : g_sq
        logic [2*FB+1:0] sq;

        assign sq = m_reg[s-1] * m_reg[s-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
        end

        always_ff @(posedge clk)
        begin
            e_reg[s] <= e_reg[s-1];
            if (sq[2*FB+1])
            begin
                m_reg[s]    <= sq[2*FB+1:FB+1];
                frac_reg[s] <= {frac_reg[s-1][FB-2:0], 1'b1};
            end
            else
            begin
                m_reg[s]    <= sq[2*FB:FB];
                frac_reg[s] <= {frac_reg[s-1][FB-2:0], 1'b0};
            end
        end
    end

    assign out_valid = valid_reg[FB];
    assign y         = {e_reg[FB], frac_reg[FB]};

endmodule

`default_nettype wire

// ----- sv/rrco_isqrt.sv -----
// pipelined integer square root of a 64 bit value, one root bit per stage
// uses rrco_pkg for the stage count
`timescale 1ns / 1ps
`default_nettype none

module rrco_isqrt (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [63:0] x,
    output logic             out_valid,
    output logic [31:0]      root
);

    localparam int NS = rrco_pkg::ISQ_STAGES;

    logic [63:0] x_reg     [0:NS-1];
    logic [63:0] res_reg   [0:NS-1];
    logic        valid_reg [0:NS-1];

    for (genvar i = 0; i < NS; i++)
    begin : g_st
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*i);
        logic [63:0] xi;
        logic [63:0] ri;
        logic        vi;
        logic [63:0] trial;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign xi = x;
            assign ri = '0;
            assign vi = in_valid;
        end
        else
        begin : g_next
            assign xi = x_reg[i-1];
            assign ri = res_reg[i-1];
            assign vi = valid_reg[i-1];
        end

        assign trial = ri + BIT;
        assign ge    = (xi >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else
            begin
                valid_reg[i] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[i]   <= ge ? (xi - trial) : xi;
            res_reg[i] <= ge ? ((ri >> 1) + BIT) : (ri >> 1);
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign root      = res_reg[NS-1][31:0];

endmodule

`default_nettype wire

// ----- sv/rayleigh_runup_cumulative_overload.sv -----
// top level: cumulative overload over rayleigh runup quantiles, apb registers
// depends on rrco_pkg, rrco_log2, rrco_isqrt
`timescale 1ns / 1ps
`default_nettype none

// channel    | direction | content
// s_axis     | in        | mean_waves, runup_two_percent, position_height, water_level
// m_axis     | out       | overload (q32.16, saturating)
// apb        | in/out    | six 32 bit registers at byte address 4*i
//
// the N waves of an item stream one per cycle through the log2 / sqrt /
// divide pipeline (122 deep), after a pass of the top log term and before
// a 64 step final divide by N.
// reset clears control state and loads register defaults.
// a waiting result is held in the output register while the next item runs.

module rayleigh_runup_cumulative_overload #(
    parameter int MAX_WAVES = rrco_pkg::MAX_WAVES
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // [31:0] mean_waves, [62:32] runup_two_percent, [94:63] position_height,
    // [126:95] water_level
    input  wire logic [127:0] s_axis_tdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [47:0] overload
    output logic [47:0]       m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int NW = $clog2(MAX_WAVES + 1);
    localparam int XW = $clog2(MAX_WAVES + 2);
    localparam int LW = $clog2(XW) + rrco_pkg::LOG_FRAC_BITS;
    localparam int DW = rrco_pkg::DW;
    localparam int NS = rrco_pkg::ISQ_STAGES;
    localparam int NQ = rrco_pkg::DIV_STAGES;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_TOP   = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_MUL2  = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [1:0] CLS_ZERO = 2'd0;
    localparam logic [1:0] CLS_ONE  = 2'd1;
    localparam logic [1:0] CLS_DIV  = 2'd2;

    // configuration registers
    logic [14:0] wave_count_reg;
    logic [31:0] crit_vel_reg;
    logic [31:0] load_factor_reg;
    logic [31:0] strength_reg;
    logic [31:0] vel_coeff_reg;
    logic [31:0] gravity_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_count_reg  <= rrco_pkg::RST_WAVE_COUNT;
            crit_vel_reg    <= rrco_pkg::RST_CRIT_VEL;
            load_factor_reg <= rrco_pkg::RST_LOAD_FACTOR;
            strength_reg    <= rrco_pkg::RST_STRENGTH;
            vel_coeff_reg   <= rrco_pkg::RST_VEL_COEFF;
            gravity_reg     <= rrco_pkg::RST_GRAVITY;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                rrco_pkg::REG_WAVE_COUNT:  wave_count_reg  <= pwdata[14:0];
                rrco_pkg::REG_CRIT_VEL:    crit_vel_reg    <= pwdata;
                rrco_pkg::REG_LOAD_FACTOR: load_factor_reg <= pwdata;
                rrco_pkg::REG_STRENGTH:    strength_reg    <= pwdata;
                rrco_pkg::REG_VEL_COEFF:   vel_coeff_reg   <= pwdata;
                rrco_pkg::REG_GRAVITY:     gravity_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            rrco_pkg::REG_WAVE_COUNT:  prdata = {17'd0, wave_count_reg};
            rrco_pkg::REG_CRIT_VEL:    prdata = crit_vel_reg;
            rrco_pkg::REG_LOAD_FACTOR: prdata = load_factor_reg;
            rrco_pkg::REG_STRENGTH:    prdata = strength_reg;
            rrco_pkg::REG_VEL_COEFF:   prdata = vel_coeff_reg;
            rrco_pkg::REG_GRAVITY:     prdata = gravity_reg;
            default:                   prdata = '0;
        endcase
    end

    // critical term alpha_s * uc^2, registered through cvsq_reg, pc_lo_reg / pc_hi_reg and crit_reg after a write
    logic [47:0] cvsq_reg;
    logic [55:0] pc_lo_reg;
    logic [55:0] pc_hi_reg;
    logic [63:0] crit_reg;
    logic [79:0] crit_sum;

    assign crit_sum = {pc_hi_reg, 24'd0} + {24'd0, pc_lo_reg};

    always_ff @(posedge clk)
    begin
        cvsq_reg  <= 48'((64'(crit_vel_reg) * 64'(crit_vel_reg)) >> 16);
        pc_lo_reg <= 56'(strength_reg) * 56'(cvsq_reg[23:0]);
        pc_hi_reg <= 56'(strength_reg) * 56'(cvsq_reg[47:24]);
        crit_reg  <= crit_sum[79:16];
    end

    // sequencer
    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     n_comb;
    logic [NW-1:0]     x_reg;
    logic [NW-1:0]     cnt_reg;
    logic [31:0]       mean_reg;
    logic [30:0]       r2p_reg;
    logic signed [32:0] delta_reg;
    logic [LW-1:0]     top_reg;
    logic [63:0]       sum_reg;
    logic [63:0]       fm_lo_reg;
    logic [63:0]       fm_hi_reg;
    logic [63:0]       qnum_reg;
    logic [63:0]       quot_reg;
    logic [NW-1:0]     rem_reg;
    logic [5:0]        step_reg;
    logic [47:0]       res_reg;
    logic              out_valid_reg;
    logic [47:0]       out_data_reg;

    logic          in_xfer;
    logic          out_free;
    logic          log_in_valid;
    logic [XW-1:0] log_in_x;
    logic          log_out_valid;
    logic [LW-1:0] lm;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign n_comb = (32'(wave_count_reg) > 32'(MAX_WAVES)) ? NW'(MAX_WAVES)
                                                           : NW'(wave_count_reg);

    always_comb
    begin
        log_in_valid = 1'b0;
        log_in_x     = XW'(x_reg);
        if (in_xfer && n_comb != '0)
        begin
            log_in_valid = 1'b1;
            log_in_x     = XW'(n_comb) + XW'(1);
        end
        else if (state_reg == ST_RUN)
        begin
            log_in_valid = 1'b1;
        end
    end

    // final stages: mean * sum, then divide by n
    logic [95:0]   fm_sum;
    logic [63:0]   fm_sat;
    logic [NW:0]   qsh;
    logic          qge;

    assign fm_sum = {fm_hi_reg, 32'd0} + {32'd0, fm_lo_reg};
    assign fm_sat = (fm_sum[95:80] != '0) ? rrco_pkg::SAT64 : fm_sum[79:16];
    assign qsh    = {rem_reg, qnum_reg[63]};
    assign qge    = (qsh >= {1'b0, n_reg});

    logic          v11_reg;
    logic [63:0]   term_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = (n_comb == '0) ? ST_OUT : ST_TOP;
                end
            end
            ST_TOP:
            begin
                if (log_out_valid)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (x_reg == NW'(1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cnt_reg == n_reg)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DIV;
            ST_DIV:
            begin
                if (step_reg == 6'(rrco_pkg::QUOT_STEPS - 1))
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                cnt_reg <= '0;
            end
            else if (v11_reg)
            begin
                cnt_reg <= cnt_reg + NW'(1);
            end
            if (state_reg == ST_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            n_reg     <= n_comb;
            mean_reg  <= s_axis_tdata[31:0];
            r2p_reg   <= s_axis_tdata[62:32];
            delta_reg <= $signed({s_axis_tdata[94], s_axis_tdata[94:63]})
                       - $signed({s_axis_tdata[126], s_axis_tdata[126:95]});
            sum_reg   <= '0;
            res_reg   <= '0;
        end
        else if (v11_reg)
        begin
            sum_reg <= (rrco_pkg::SAT64 - sum_reg < term_reg) ? rrco_pkg::SAT64
                                                              : sum_reg + term_reg;
        end
        if (state_reg == ST_TOP && log_out_valid)
        begin
            top_reg <= lm;
            x_reg   <= n_reg;
        end
        else if (state_reg == ST_RUN)
        begin
            x_reg <= x_reg - NW'(1);
        end
        if (state_reg == ST_MUL)
        begin
            fm_lo_reg <= 64'(mean_reg) * 64'(sum_reg[31:0]);
            fm_hi_reg <= 64'(mean_reg) * 64'(sum_reg[63:32]);
        end
        if (state_reg == ST_MUL2)
        begin
            qnum_reg <= fm_sat;
            quot_reg <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            qnum_reg <= {qnum_reg[62:0], 1'b0};
            quot_reg <= {quot_reg[62:0], qge};
            rem_reg  <= qge ? NW'(qsh - {1'b0, n_reg}) : NW'(qsh);
            step_reg <= step_reg + 6'd1;
            if (step_reg == 6'(rrco_pkg::QUOT_STEPS - 1))
            begin
                res_reg <= (quot_reg[62:47] != '0) ? rrco_pkg::OUT_MAX
                                                   : {quot_reg[46:0], qge};
            end
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // wave pipeline
    rrco_log2 #(
        .XW (XW)
    ) u_log2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (log_in_valid),
        .x         (log_in_x),
        .out_valid (log_out_valid),
        .y         (lm)
    );

    logic          wv0;
    logic          v1_reg;
    logic [DW-1:0] d_reg;
    logic          v2_reg;
    logic [31:0]   r2_reg;
    logic [DW+31:0] dprod;

    assign wv0   = log_out_valid && (state_reg != ST_TOP);
    assign dprod = {32'd0, d_reg} * {{DW{1'b0}}, rrco_pkg::RECIP_LOG2_50};

    logic          va_valid;
    logic [31:0]   r_root;
    logic          v3_reg;
    logic [31:0]   rr_reg;
    logic [61:0]   rrprod;

    assign rrprod = {31'd0, r2p_reg} * {30'd0, r_root};

    logic                 v4_reg;
    logic [63:0]          gr_reg;
    logic [31:0]          rr4_reg;
    logic signed [DW-1:0] num4_reg;

    logic          vb_valid;
    logic [31:0]   s_root;

    rrco_isqrt u_isqrt_quantile (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v2_reg),
        .x         ({2'd0, r2_reg, 30'd0}),
        .out_valid (va_valid),
        .root      (r_root)
    );

    rrco_isqrt u_isqrt_velocity (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .x         (gr_reg),
        .out_valid (vb_valid),
        .root      (s_root)
    );

    // runup and height margin ride alongside the velocity root
    logic [31:0]          dl_rr  [0:NS-1];
    logic signed [DW-1:0] dl_num [0:NS-1];

    always_ff @(posedge clk)
    begin
        dl_rr[0]  <= rr4_reg;
        dl_num[0] <= num4_reg;
    end

    for (genvar i = 1; i < NS; i++)
    begin : g_dl
        always_ff @(posedge clk)
        begin
            dl_rr[i]  <= dl_rr[i-1];
            dl_num[i] <= dl_num[i-1];
        end
    end

    // clamp factor class and division setup
    logic [DW+1:0] num_x4;
    logic [1:0]    cls_comb;
    logic          v5_reg;
    logic [47:0]   vel5_reg;
    logic [31:0]   rr5_reg;
    logic [31:0]   rem5_reg;
    logic [1:0]    cls5_reg;

    assign num_x4 = {dl_num[NS-1], 2'b00};

    always_comb
    begin
        if (dl_rr[NS-1] == '0 || dl_num[NS-1][DW-1] || dl_num[NS-1] == '0)
        begin
            cls_comb = CLS_ZERO;
        end
        else if (num_x4 >= {{(DW-30){1'b0}}, dl_rr[NS-1]})
        begin
            cls_comb = CLS_ONE;
        end
        else
        begin
            cls_comb = CLS_DIV;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= (top_reg > lm) ? DW'(top_reg - lm) : '0;
        r2_reg   <= dprod[63:32];
        rr_reg   <= rrprod[61:30];
        gr_reg   <= 64'(gravity_reg) * 64'(rr_reg);
        rr4_reg  <= rr_reg;
        num4_reg <= $signed({{(DW-32){1'b0}}, rr_reg})
                  - $signed({{(DW-33){delta_reg[32]}}, delta_reg});
        vel5_reg <= 48'((64'(vel_coeff_reg) * 64'(s_root)) >> 16);
        rr5_reg  <= dl_rr[NS-1];
        rem5_reg <= num_x4[31:0];
        cls5_reg <= cls_comb;
    end

    // restoring divide for the clamp factor, one quotient bit per stage
    logic [31:0] dq_rem   [0:NQ-1];
    logic [15:0] dq_quot  [0:NQ-1];
    logic [31:0] dq_rr    [0:NQ-1];
    logic [47:0] dq_vel   [0:NQ-1];
    logic [1:0]  dq_cls   [0:NQ-1];
    logic        dq_valid [0:NQ-1];

    for (genvar j = 0; j < NQ; j++)
    begin : g_div
        logic [31:0] rem_in;
        logic [15:0] quot_in;
        logic [31:0] rr_in;
        logic [47:0] vel_in;
        logic [1:0]  cls_in;
        logic        valid_in;
        logic [32:0] rsh;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign rem_in   = rem5_reg;
            assign quot_in  = '0;
            assign rr_in    = rr5_reg;
            assign vel_in   = vel5_reg;
            assign cls_in   = cls5_reg;
            assign valid_in = v5_reg;
        end
        else
        begin : g_next
            assign rem_in   = dq_rem[j-1];
            assign quot_in  = dq_quot[j-1];
            assign rr_in    = dq_rr[j-1];
            assign vel_in   = dq_vel[j-1];
            assign cls_in   = dq_cls[j-1];
            assign valid_in = dq_valid[j-1];
        end

        assign rsh = {rem_in, 1'b0};
        assign ge  = (rsh >= {1'b0, rr_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dq_valid[j] <= 1'b0;
            end
            else
            begin
                dq_valid[j] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            dq_rem[j]  <= ge ? 32'(rsh - {1'b0, rr_in}) : rsh[31:0];
            dq_quot[j] <= {quot_in[14:0], ge};
            dq_rr[j]   <= rr_in;
            dq_vel[j]  <= vel_in;
            dq_cls[j]  <= cls_in;
        end
    end

    // front velocity and load terms
    logic [16:0] fclamp;
    logic [64:0] uprod;
    logic        v6_reg;
    logic [47:0] u_reg;
    logic        v7_reg;
    logic [63:0] p_ll_reg;
    logic [47:0] p_hl_reg;
    logic [31:0] p_hh_reg;
    logic [95:0] sq96;
    logic        v8_reg;
    logic [63:0] uu_reg;
    logic        v9_reg;
    logic [63:0] pa_reg;
    logic [63:0] pb_reg;
    logic [95:0] ld96;
    logic        v10_reg;
    logic [63:0] load_reg;

    always_comb
    begin
        case (dq_cls[NQ-1])
            CLS_ONE: fclamp = 17'h10000;
            CLS_DIV: fclamp = {1'b0, dq_quot[NQ-1]};
            default: fclamp = '0;
        endcase
    end

    assign uprod = {17'd0, dq_vel[NQ-1]} * {48'd0, fclamp};
    assign sq96  = {p_hh_reg, 64'd0} + {15'd0, p_hl_reg, 33'd0} + {32'd0, p_ll_reg};
    assign ld96  = {pa_reg, 32'd0} + {32'd0, pb_reg};

    always_ff @(posedge clk)
    begin
        u_reg    <= uprod[63:16];
        p_ll_reg <= 64'(u_reg[31:0]) * 64'(u_reg[31:0]);
        p_hl_reg <= 48'(u_reg[47:32]) * 48'(u_reg[31:0]);
        p_hh_reg <= 32'(u_reg[47:32]) * 32'(u_reg[47:32]);
        uu_reg   <= (sq96[95:80] != '0) ? rrco_pkg::SAT64 : sq96[79:16];
        pa_reg   <= 64'(load_factor_reg) * 64'(uu_reg[63:32]);
        pb_reg   <= 64'(load_factor_reg) * 64'(uu_reg[31:0]);
        load_reg <= (ld96[95:80] != '0) ? rrco_pkg::SAT64 : ld96[79:16];
        term_reg <= (load_reg > crit_reg) ? (load_reg - crit_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
        end
        else
        begin
            v1_reg  <= wv0;
            v2_reg  <= v1_reg;
            v3_reg  <= va_valid;
            v4_reg  <= v3_reg;
            v5_reg  <= vb_valid;
            v6_reg  <= dq_valid[NQ-1];
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
        end
    end

endmodule

`default_nettype wire
